// ===== sv/qmlm_pkg.sv =====
// ============================================================================
// qmlm_pkg
// Shared types, result codes and default sizes for the queued mutex lock
// manager.
// ============================================================================
`default_nettype none

package qmlm_pkg;

    // Default sizes
    localparam int NUM_LOCKS_DEF    = 4;
    localparam int WAIT_DEPTH_DEF   = 16;
    localparam int PROC_ID_BITS_DEF = 8;

    // Fixed field widths on the ports
    localparam int CMD_W     = 1;
    localparam int LOCK_ID_W = 2;
    localparam int PROC_ID_W = 8;
    localparam int STATUS_W  = 3;
    localparam int HANDED_W  = 8;
    localparam int LEFT_W    = 5;

    // Operation codes
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

    // Result codes
    localparam logic [STATUS_W-1:0] STAT_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_QUEUED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FREED   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_HANDED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ERROR   = 3'd4;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture request, launch queue memory read
        logic exec;   // apply the update, register the result
    } ctrl_t;

endpackage : qmlm_pkg

`default_nettype wire

// ===== sv/qmlm_ctrl.sv =====
// ============================================================================
// qmlm_ctrl
// Two-state sequencer: takes a request when idle, then executes it in the
// datapath in the following cycle.
// ============================================================================
`default_nettype none

module qmlm_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    output qmlm_pkg::ctrl_t     ctrl
);
    import qmlm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy      = 1'b0;
        ctrl.load = 1'b0;
        ctrl.exec = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = start;
            end
            ST_EXEC:
            begin
                busy      = 1'b1;
                ctrl.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // A transfer is always followed by exactly one busy cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter execute");

    a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("execute lasted more than one cycle");

    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> ctrl.exec)
        else $error("load not followed by execute");

endmodule : qmlm_ctrl

`default_nettype wire

// ===== sv/qmlm_dp.sv =====
// ============================================================================
// qmlm_dp
// Lock table, per-lock wait FIFO pointers, shared wait-queue memory and
// result registers.
// ============================================================================
`default_nettype none

module qmlm_dp
#(
    parameter int NUM_LOCKS    = qmlm_pkg::NUM_LOCKS_DEF,
    parameter int WAIT_DEPTH   = qmlm_pkg::WAIT_DEPTH_DEF,
    parameter int PROC_ID_BITS = qmlm_pkg::PROC_ID_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire qmlm_pkg::ctrl_t                ctrl,
    input  wire logic [qmlm_pkg::CMD_W-1:0]     cmd,
    input  wire logic [qmlm_pkg::LOCK_ID_W-1:0] lock_id,
    input  wire logic [qmlm_pkg::PROC_ID_W-1:0] proc_id,
    output logic                                done,
    output logic [qmlm_pkg::STATUS_W-1:0]       status,
    output logic [qmlm_pkg::HANDED_W-1:0]       handed_to,
    output logic [qmlm_pkg::LEFT_W-1:0]         waiters_left
);
    import qmlm_pkg::*;

    localparam int LK_W   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int LK_EXT = (LK_W > LOCK_ID_W) ? LK_W : LOCK_ID_W;
    localparam int HD_W   = $clog2(WAIT_DEPTH);
    localparam int SUM_W  = HD_W + 1;
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int ID_W   = (PROC_ID_BITS < PROC_ID_W) ? PROC_ID_BITS : PROC_ID_W;
    localparam int MEM_N  = NUM_LOCKS * WAIT_DEPTH;
    localparam int ADDR_W = (MEM_N > 1) ? $clog2(MEM_N) : 1;

    // Per-lock state
    logic             held_reg [NUM_LOCKS];
    logic [HD_W-1:0]  head_reg [NUM_LOCKS];
    logic [CNT_W-1:0] cnt_reg  [NUM_LOCKS];

    // Wait-queue memory
    logic [ID_W-1:0]  mem [MEM_N];
    logic [ID_W-1:0]  rd_data_reg;

    // Captured request
    logic [CMD_W-1:0] cmd_reg;
    logic [LK_W-1:0]  lk_reg;
    logic             in_range_reg;
    logic [ID_W-1:0]  pid_reg;

    // Result registers
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [HANDED_W-1:0] handed_reg;
    logic [LEFT_W-1:0]   left_reg;

    // Request decode at the transfer
    logic [LK_EXT-1:0] lk_ext;
    logic [LK_W-1:0]   lk_idx;
    logic              in_range;
    logic [HD_W-1:0]   rd_head;
    logic [ADDR_W-1:0] rd_addr;

    assign lk_ext   = LK_EXT'(lock_id);
    assign lk_idx   = lk_ext[LK_W-1:0];
    assign in_range = (32'(lock_id) < NUM_LOCKS);
    assign rd_head  = in_range ? head_reg[lk_idx] : '0;
    assign rd_addr  = in_range ? ADDR_W'(ADDR_W'(lk_idx) * ADDR_W'(WAIT_DEPTH)
                                         + ADDR_W'(rd_head)) : '0;

    // Execute-cycle update
    logic              cur_held;
    logic [HD_W-1:0]   cur_head;
    logic [CNT_W-1:0]  cur_cnt;
    logic [SUM_W-1:0]  tail_sum;
    logic [HD_W-1:0]   tail_slot;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic              upd_en;
    logic              held_next;
    logic [HD_W-1:0]   head_next;
    logic [CNT_W-1:0]  cnt_next;
    logic [STATUS_W-1:0] status_next;
    logic [HANDED_W-1:0] handed_next;
    logic [CNT_W-1:0]  left_next;

    assign cur_held  = in_range_reg ? held_reg[lk_reg] : 1'b0;
    assign cur_head  = in_range_reg ? head_reg[lk_reg] : '0;
    assign cur_cnt   = in_range_reg ? cnt_reg[lk_reg]  : '0;
    assign tail_sum  = SUM_W'(cur_head) + SUM_W'(cur_cnt);
    assign tail_slot = (tail_sum >= SUM_W'(WAIT_DEPTH))
                       ? HD_W'(tail_sum - SUM_W'(WAIT_DEPTH)) : HD_W'(tail_sum);
    assign wr_addr   = ADDR_W'(ADDR_W'(lk_reg) * ADDR_W'(WAIT_DEPTH)
                               + ADDR_W'(tail_slot));

    always_comb
    begin
        wr_en       = 1'b0;
        upd_en      = 1'b0;
        held_next   = cur_held;
        head_next   = cur_head;
        cnt_next    = cur_cnt;
        status_next = STAT_ERROR;
        handed_next = '0;
        left_next   = '0;
        if (in_range_reg)
        begin
            left_next = cur_cnt;
            if (cmd_reg == CMD_ACQUIRE)
            begin
                priority if (!cur_held)
                begin
                    upd_en      = 1'b1;
                    held_next   = 1'b1;
                    status_next = STAT_GRANTED;
                end
                else if (cur_cnt == CNT_W'(WAIT_DEPTH))
                begin
                    status_next = STAT_ERROR;
                end
                else
                begin
                    upd_en      = 1'b1;
                    wr_en       = 1'b1;
                    cnt_next    = cur_cnt + CNT_W'(1);
                    left_next   = cur_cnt + CNT_W'(1);
                    status_next = STAT_QUEUED;
                end
            end
            else
            begin
                priority if (!cur_held)
                begin
                    status_next = STAT_ERROR;
                end
                else if (cur_cnt == '0)
                begin
                    upd_en      = 1'b1;
                    held_next   = 1'b0;
                    left_next   = '0;
                    status_next = STAT_FREED;
                end
                else
                begin
                    // hand ownership to the oldest waiter
                    upd_en      = 1'b1;
                    head_next   = (cur_head == HD_W'(WAIT_DEPTH - 1))
                                  ? '0 : cur_head + HD_W'(1);
                    cnt_next    = cur_cnt - CNT_W'(1);
                    left_next   = cur_cnt - CNT_W'(1);
                    handed_next = HANDED_W'(rd_data_reg);
                    status_next = STAT_HANDED;
                end
            end
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg      <= cmd;
            lk_reg       <= lk_idx;
            in_range_reg <= in_range;
            pid_reg      <= proc_id[ID_W-1:0];
        end
    end

    // Queue memory: write on enqueue, read head at the transfer
    always_ff @(posedge clk)
    begin
        if (ctrl.exec && wr_en)
        begin
            mem[wr_addr] <= pid_reg;
        end
        if (ctrl.load)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Lock table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                held_reg[i] <= 1'b0;
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else if (ctrl.exec && upd_en)
        begin
            held_reg[lk_reg] <= held_next;
            head_reg[lk_reg] <= head_next;
            cnt_reg[lk_reg]  <= cnt_next;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.exec;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            status_reg <= status_next;
            handed_reg <= handed_next;
            left_reg   <= LEFT_W'(left_next);
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign handed_to    = handed_reg;
    assign waiters_left = left_reg;

    // A waiter can only exist behind an owner
    for (genvar g = 0; g < NUM_LOCKS; g++)
    begin : g_chk
        a_wait_held: assert property (@(posedge clk) disable iff (!rst_n)
            (cnt_reg[g] != '0) |-> held_reg[g])
            else $error("waiters queued on a free lock");
    end

    a_queued_left: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STAT_QUEUED && WAIT_DEPTH < 32) |-> (left_reg != '0))
        else $error("queued result reports empty queue");

    a_handed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != STAT_HANDED) |-> (handed_reg == '0))
        else $error("handed_to set without hand-over");

endmodule : qmlm_dp

`default_nettype wire

// ===== sv/queued_mutex_lock_manager.sv =====
// ============================================================================
// queued_mutex_lock_manager
// Lock manager for a set of mutexes, each with a FIFO of waiting process ids.
// ============================================================================
// Usage:
//   Request channel: drive cmd, lock_id and proc_id and raise start; the
//   transfer happens at a clock edge where start is high and busy is low.
//   An acquire grants a free lock or queues the caller; a release frees the
//   lock or hands it to the oldest waiter, whose id is reported.
//   Result channel: done is high for exactly one cycle with status,
//   handed_to and waiters_left valid; the receiver must take it then.
//   Timing: the transfer moves the sequencer into its execute state, and
//   done and the result are registered from that state.
//   Pacing: busy holds off new requests while one executes, which takes the
//   head read of the wait-queue memory in the transfer cycle followed by the
//   read-modify-write of the lock entry in the execute cycle. A new request
//   may be taken in the same cycle that the previous result is shown.
//   Reset: every lock free and every wait queue empty; queue memory contents
//   are not cleared and need no clearing pass.
// ============================================================================
`default_nettype none

module queued_mutex_lock_manager
#(
    parameter int NUM_LOCKS    = qmlm_pkg::NUM_LOCKS_DEF,
    parameter int WAIT_DEPTH   = qmlm_pkg::WAIT_DEPTH_DEF,
    parameter int PROC_ID_BITS = qmlm_pkg::PROC_ID_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [qmlm_pkg::CMD_W-1:0]     cmd,
    input  wire logic [qmlm_pkg::LOCK_ID_W-1:0] lock_id,
    input  wire logic [qmlm_pkg::PROC_ID_W-1:0] proc_id,
    output logic                                done,
    output logic [qmlm_pkg::STATUS_W-1:0]       status,
    output logic [qmlm_pkg::HANDED_W-1:0]       handed_to,
    output logic [qmlm_pkg::LEFT_W-1:0]         waiters_left
);
    import qmlm_pkg::*;

    ctrl_t ctrl;

    // Sequencer
    qmlm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    // Lock table and queues
    qmlm_dp
    #(
        .NUM_LOCKS    (NUM_LOCKS),
        .WAIT_DEPTH   (WAIT_DEPTH),
        .PROC_ID_BITS (PROC_ID_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cmd          (cmd),
        .lock_id      (lock_id),
        .proc_id      (proc_id),
        .done         (done),
        .status       (status),
        .handed_to    (handed_to),
        .waiters_left (waiters_left)
    );

endmodule : queued_mutex_lock_manager

`default_nettype wire
